@@ hw/rtl/pfr_pkg.sv @@
`default_nettype none
package pfr_pkg;
    localparam int unsigned ADDR_WIDTH = 32;
    localparam int unsigned IDLE_WIDTH = 16;
    localparam logic [IDLE_WIDTH-1:0] IDLE_MAX = 16'hFFFF;
    localparam logic [IDLE_WIDTH-1:0] IDLE_RESET = 16'd64;
    localparam logic [IDLE_WIDTH-1:0] THRESHOLD_RESET = 16'd44;
endpackage
`default_nettype wire

@@ hw/rtl/pfr_front.sv @@
`default_nettype none
// Front: registers incoming addresses into a two-entry queue, exposes the head
module pfr_front #(
    parameter int unsigned PAGE_WIDTH = 20,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           in_addr,
    output logic                       head_valid,
    output logic [PAGE_WIDTH-1:0]      head_page,
    input  wire logic                  head_pop
);
    logic [PAGE_WIDTH-1:0] q_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    logic push;

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head_page  = q_reg[rd_reg];

    // page extraction and queue write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_addr[PAGE_SHIFT +: PAGE_WIDTH];
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (head_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, head_pop};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/pfr_back.sv @@
`default_nettype none
// Back: frame table, associative match, serial victim scan, result register
module pfr_back #(
    parameter int unsigned FRAMES      = 64,
    parameter int unsigned PAGE_WIDTH  = 20,
    parameter int unsigned STAMP_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [15:0]           threshold,
    input  wire logic                  head_valid,
    input  wire logic [PAGE_WIDTH-1:0] head_page,
    output logic                       head_pop,
    output logic                       out_valid,
    output logic                       out_hit,
    input  wire logic                  out_ready
);
    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_HIT  = 2'd3;

    logic [FRAMES-1:0]            valid_reg;
    logic [FRAMES-1:0]            init_reg;
    logic [PAGE_WIDTH-1:0]        page_reg  [FRAMES];
    logic [15:0]                  idle_mem  [FRAMES];
    logic [15:0]                  prev_mem  [FRAMES];
    logic [STAMP_WIDTH-1:0]       stamp_mem [FRAMES];
    logic [15:0]                  rd_idle_reg, rd_prev_reg;
    logic [STAMP_WIDTH-1:0]       rd_stamp_reg;
    logic                         rd_init_reg;
    logic [STAMP_WIDTH-1:0]       ctr_reg;
    logic [1:0]                   state_reg;
    logic [IW-1:0]                idx_reg, victim_reg;
    logic                         searching_reg;
    logic [STAMP_WIDTH-1:0]       vstamp_reg;
    logic [PAGE_WIDTH-1:0]        page_hold_reg;
    logic                         out_valid_reg, out_hit_reg;

    logic [FRAMES-1:0]      match;
    logic                   any_hit;
    logic [IW-1:0]          hit_idx;
    logic                   start;
    logic                   zero_miss;
    logic [IW-1:0]          rd_addr;
    logic [15:0]            cur_idle, cur_prev, bar;
    logic [STAMP_WIDTH-1:0] cur_stamp;
    logic                   take;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [15:0]            wr_idle, wr_prev;
    logic [STAMP_WIDTH-1:0] wr_stamp;

    // associative match, first match wins
    always_comb
    begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (page_reg[i] == head_page);
            if (match[i])
            begin
                hit_idx = IW'(i);
                any_hit = 1'b1;
            end
        end
    end

    assign start     = (state_reg == ST_IDLE) && head_valid && !out_valid_reg;
    assign head_pop  = start;
    assign zero_miss = start && !any_hit && (head_page == '0);
    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;

    // read address: next frame while scanning, matching frame on a hit, else frame 0
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr = (idx_reg == IW'(FRAMES - 1)) ? '0 : idx_reg + 1'b1;
        end
        else if (any_hit)
        begin
            rd_addr = hit_idx;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    // registered counters; a frame never written reads as its reset value
    assign cur_idle  = rd_init_reg ? rd_idle_reg : pfr_pkg::IDLE_RESET;
    assign cur_prev  = rd_init_reg ? rd_prev_reg : '0;
    assign cur_stamp = rd_init_reg ? rd_stamp_reg : '0;
    assign bar       = (threshold > cur_prev) ? threshold : cur_prev;
    // frame 0 is the default choice and never beats itself
    assign take      = (idx_reg != '0) && (cur_idle > bar) && (cur_stamp < vstamp_reg);

    // single write port into the counter memory
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_idle  = '0;
        wr_prev  = '0;
        wr_stamp = ctr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                wr_en = zero_miss;
            end
            ST_SCAN:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_idle  = (cur_idle != pfr_pkg::IDLE_MAX) ? cur_idle + 16'd1 : cur_idle;
                wr_prev  = cur_prev;
                wr_stamp = cur_stamp;
            end
            ST_HIT:
            begin
                wr_en   = 1'b1;
                wr_addr = victim_reg;
                wr_prev = cur_idle;
            end
            ST_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = victim_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // counter memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            idle_mem[wr_addr]  <= wr_idle;
            prev_mem[wr_addr]  <= wr_prev;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        rd_idle_reg  <= idle_mem[rd_addr];
        rd_prev_reg  <= prev_mem[rd_addr];
        rd_stamp_reg <= stamp_mem[rd_addr];
    end

    // page cells, held page and victim stamp
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            page_hold_reg <= head_page;
        end
        if ((state_reg == ST_SCAN)
            && ((idx_reg == '0) || (searching_reg && valid_reg[idx_reg] && take)))
        begin
            vstamp_reg <= cur_stamp;
        end
        if (zero_miss)
        begin
            page_reg[0] <= '0;
        end
        if (state_reg == ST_LOAD)
        begin
            page_reg[victim_reg] <= page_hold_reg;
        end
    end

    // control: sequencer, valid and written bits, stamp counter, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            init_reg      <= '0;
            rd_init_reg   <= 1'b0;
            ctr_reg       <= STAMP_WIDTH'(1);
            idx_reg       <= '0;
            victim_reg    <= '0;
            searching_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            rd_init_reg <= init_reg[rd_addr];
            if (wr_en)
            begin
                init_reg[wr_addr] <= 1'b1;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (any_hit)
                        begin
                            victim_reg <= hit_idx;
                            state_reg  <= ST_HIT;
                        end
                        else if (head_page == '0)
                        begin
                            ctr_reg       <= ctr_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_hit_reg   <= 1'b0;
                            valid_reg[0]  <= 1'b1;
                        end
                        else
                        begin
                            idx_reg       <= '0;
                            victim_reg    <= '0;
                            searching_reg <= 1'b1;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_HIT:
                begin
                    ctr_reg       <= ctr_reg + 1'b1;
                    out_valid_reg <= 1'b1;
                    out_hit_reg   <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (searching_reg)
                    begin
                        if (!valid_reg[idx_reg])
                        begin
                            victim_reg    <= idx_reg;
                            searching_reg <= 1'b0;
                        end
                        else if (take)
                        begin
                            victim_reg <= idx_reg;
                        end
                    end
                    if (idx_reg == IW'(FRAMES - 1))
                    begin
                        state_reg <= ST_LOAD;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    valid_reg[victim_reg] <= 1'b1;
                    ctr_reg       <= ctr_reg + 1'b1;
                    out_valid_reg <= 1'b1;
                    out_hit_reg   <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_load_miss: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> out_valid_reg && !out_hit_reg)
        else $error("load must produce a miss result");
    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HIT |=> out_valid_reg && out_hit_reg)
        else $error("hit must produce a hit result");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !head_pop)
        else $error("item taken while busy");
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ctr_reg == $past(ctr_reg) + 1'b1)
        else $error("stamp not advanced on result");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/page_frame_replacement.sv @@
`default_nettype none
// Page frame replacement over FRAMES frames with idle-interval aging. A miss on
// page 0 is answered from the idle state and a hit from the hit state, since the
// hit frame's counters are read from memory first; any other miss walks every
// frame once through one shared compare unit before the load state answers it.
// A two-entry input queue takes new addresses while it has room, during the scan
// and while a result waits in its output register. The user writes idle_threshold
// through cfg_we/cfg_data while the block is idle; the block does not enforce it.
module page_frame_replacement #(
    parameter int unsigned FRAMES      = 64,
    parameter int unsigned PAGE_SHIFT  = 12,
    parameter int unsigned STAMP_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] address
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata   // [0] hit, [7:1] zero
);
    localparam int unsigned PAGE_WIDTH = 32 - PAGE_SHIFT;

    logic [15:0] thr_reg;
    logic hv, pop, hit;
    logic [PAGE_WIDTH-1:0] hp;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= pfr_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    pfr_front #(.PAGE_WIDTH(PAGE_WIDTH), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_addr(s_axis_tdata),
        .head_valid(hv), .head_page(hp), .head_pop(pop)
    );

    pfr_back #(.FRAMES(FRAMES), .PAGE_WIDTH(PAGE_WIDTH), .STAMP_WIDTH(STAMP_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .threshold(thr_reg),
        .head_valid(hv), .head_page(hp), .head_pop(pop),
        .out_valid(m_axis_tvalid), .out_hit(hit), .out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, hit};
endmodule
`default_nettype wire

@@ verif/page_frame_replacement_tb.sv @@
module page_frame_replacement_tb;
    localparam int NFRAMES = 64;
    localparam int PSHIFT = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] address
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] hit, [7:1] zero

    page_frame_replacement dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // predictor state for the frame table
    logic                           fr_valid [NFRAMES];
    logic [19:0]                    fr_page  [NFRAMES];
    logic [pfr_pkg::IDLE_WIDTH-1:0] fr_idle  [NFRAMES];
    logic [pfr_pkg::IDLE_WIDTH-1:0] fr_prev  [NFRAMES];
    logic [31:0]                    fr_stamp [NFRAMES];
    logic [31:0]                    use_count;
    logic [pfr_pkg::IDLE_WIDTH-1:0] threshold;

    logic [7:0] hit_queue [$];
    int  errors = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  hits_seen = 0;
    int  quiet_cycles = 0;
    bit  no_idle = 0;
    logic [19:0] hot_pages [$];

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] next_stamp();
        logic [31:0] s;
        s = use_count;
        use_count = use_count + 32'd1;
        return s;
    endfunction

    // returns the expected hit flag and updates the table
    function automatic logic predict_lookup(input logic [31:0] addr);
        logic [19:0] pg;
        logic [pfr_pkg::IDLE_WIDTH-1:0] bar;
        int victim;
        bit searching;
        pg = 20'(addr >> PSHIFT);
        victim = 0;
        searching = 1;
        for (int i = 0; i < NFRAMES; i++)
        begin
            if (fr_valid[i] && fr_page[i] == pg)
            begin
                fr_prev[i] = fr_idle[i];
                fr_idle[i] = 0;
                fr_stamp[i] = next_stamp();
                return 1'b1;
            end
        end
        if (pg != 0)
        begin
            for (int i = 0; i < NFRAMES; i++)
            begin
                if (searching && !fr_valid[i])
                begin
                    victim = i;
                    searching = 0;
                end
                else if (searching)
                begin
                    bar = (threshold > fr_prev[i]) ? threshold : fr_prev[i];
                    if (fr_idle[i] > bar && fr_stamp[i] < fr_stamp[victim])
                        victim = i;
                end
                if (fr_idle[i] < pfr_pkg::IDLE_MAX)
                    fr_idle[i] = fr_idle[i] + 16'd1;
            end
        end
        fr_valid[victim] = 1;
        fr_page[victim] = pg;
        fr_idle[victim] = 0;
        fr_prev[victim] = 0;
        fr_stamp[victim] = next_stamp();
        return 1'b0;
    endfunction

    task automatic send_address(input logic [31:0] addr);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= addr;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit_queue.push_back({7'd0, predict_lookup(addr)});
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (hit_queue.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        cfg_we   <= 1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        threshold = value;
    endtask

    // result checker and sink stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tdata[0])
                    hits_seen++;
                if (hit_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    if (m_axis_tdata !== hit_queue[0])
                    begin
                        $display("%0t: hit mismatch, expected %h, actual %h",
                                 $time, hit_queue[0], m_axis_tdata);
                        errors++;
                    end
                    void'(hit_queue.pop_front());
                end
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // edges of the address field, page zero and reuse
    task automatic test_directed();
        send_address(32'h0000_0000);
        send_address(32'h0000_0FFF);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_F000);
        send_address(32'h0000_1000);
        send_address(32'h0000_0000);
        send_address(32'h8000_0000);
        send_address(32'h5555_5555);
        send_address(32'hAAAA_AAAA);
        send_address(32'h0000_1234);
    endtask

    // fill every frame, then force evictions
    task automatic test_fill_and_evict(input int rounds);
        for (int i = 1; i <= 70; i++)
            send_address(32'(i << PSHIFT));
        for (int r = 0; r < rounds; r++)
            send_address(32'(($urandom_range(200) + 1) << PSHIFT));
    endtask

    // mostly a small working set so hits and aging interact
    task automatic test_random(input int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0: a = $urandom();
                1: a = {20'd0, 12'($urandom())};
                default: a = {12'd0, 8'($urandom_range(99)), 12'($urandom())};
            endcase
            send_address(a);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        for (int i = 0; i < NFRAMES; i++)
        begin
            fr_valid[i] = 0;
            fr_page[i] = 0;
            fr_idle[i] = pfr_pkg::IDLE_RESET;
            fr_prev[i] = 0;
            fr_stamp[i] = 0;
        end
        use_count = 1;
        threshold = pfr_pkg::THRESHOLD_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_directed();
        wait_drained();
        write_threshold(16'd0);
        test_fill_and_evict(60);
        wait_drained();
        write_threshold(16'hFFFF);
        test_random(250);
        wait_drained();
        write_threshold(16'd5);
        no_idle = 1;
        test_random(300);
        no_idle = 0;
        wait_drained();
        write_threshold(16'd44);
        test_random(610);
        wait_drained();

        $display("Sent %0d addresses, checked %0d results (%0d hits).",
                 items_sent, results_seen, hits_seen);
        $display("Thresholds 0, 5, 44 and 65535 used; evictions and page zero covered.");
        if (errors == 0 && hit_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ page_frame_replacement.f @@
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_front.sv
hw/rtl/pfr_back.sv
hw/rtl/page_frame_replacement.sv
verif/page_frame_replacement_tb.sv
